>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define BRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// delayed implication: consequent must hold after the antecedent, off while in reset
`define BRB_ASSERT_DLY2(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

>>> design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// shared types, widths and helpers of the byte ring buffer
// ----------------------------------------------------------------------------
package brb_pkg;

  // store geometry
  localparam int DEPTH = 4096;
  localparam int PTR_W = $clog2(DEPTH);

  // word field widths
  localparam int OPC_W    = 2;
  localparam int DATA_W   = 8;
  localparam int OFFSET_W = 12;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = CNT_W + 1;

  localparam int IN_PACK_W   = DATA_W + OFFSET_W + CNT_W;
  localparam int IN_TDATA_W  = ((IN_PACK_W + 7) / 8) * 8;
  localparam int OUT_PACK_W  = DATA_W + CNT_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;

  typedef enum logic [OPC_W-1:0] {
    OP_APPEND  = 2'd0,
    OP_PEEK    = 2'd1,
    OP_CONSUME = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // result of one operation, before the peeked byte is known
  typedef struct packed {
    logic               is_peek;
    status_t            status;
    logic [CNT_W-1:0]   fill;
    logic [CNT_W-1:0]   dropped;
  } brb_res_t;

  // pointer plus distance, wrapped into the store; inc never exceeds DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] inc);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(inc);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> design/byte_ring_buffer_peek_consume.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_consume
// circular byte store with append, offset peek and clamped consume
// ----------------------------------------------------------------------------
// path: an accepted word passes the read wait stage, then the output register, to out_tvalid
// throughput: one word per cycle unless out_tready back-pressure stalls the output;
//   the store has one write and one read port, pointers and fill count update in the accept cycle
// reset: synchronous active-low rst_n clears pointers, fill count and valids;
//   the byte store itself is not cleared and needs no sweep
module byte_ring_buffer_peek_consume
  import brb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input word stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte, offset, count, zero pad
  input  logic [OPC_W-1:0]       in_tuser,   // opcode
  // result word stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // peek_byte, fill_level, dropped_count, zero pad
  output logic [STATUS_W-1:0]    out_tuser   // status
);

`include "assert_macros.svh"

  // input word fields
  logic [DATA_W-1:0]   data_byte;
  logic [OFFSET_W-1:0] offset;
  logic [CNT_W-1:0]    count;
  opcode_t             opcode;
  logic                in_fire;

  assign data_byte = in_tdata[DATA_W-1:0];
  assign offset    = in_tdata[DATA_W+OFFSET_W-1:DATA_W];
  assign count     = in_tdata[IN_PACK_W-1:DATA_W+OFFSET_W];
  assign opcode    = opcode_t'(in_tuser);
  assign in_fire   = in_tvalid && in_tready;

  // store ports
  logic              ram_wr_en;
  logic [PTR_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [PTR_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  brb_res_t          res;

  // result fields
  logic [DATA_W-1:0] peek_byte;
  status_t           status;
  logic [CNT_W-1:0]  fill_level;
  logic [CNT_W-1:0]  dropped_count;

  // bookkeeping: the pointer and fill-count state lives here
  brb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .opcode      (opcode),
    .data_byte   (data_byte),
    .offset      (offset),
    .count       (count),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .res         (res)
  );

  // the byte store; an append and a later peek are accepted in different cycles,
  // so the registered read always sees the written byte
  brb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // read wait stage and output register; stalls on out_tready back-pressure
  brb_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_res        (res),
    .ram_rd_data   (ram_rd_data),
    .in_ready      (in_tready),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_peek_byte (peek_byte),
    .out_status    (status),
    .out_fill      (fill_level),
    .out_dropped   (dropped_count)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_PACK_W){1'b0}}, dropped_count, fill_level, peek_byte};
  assign out_tuser = status;

  // a dropped append only happens with the store full
  `BRB_ASSERT_IMP(a_full_fill, clk, rst_n, out_tvalid && (out_tuser == ST_FULL), fill_level == CNT_W'(DEPTH))
  // fill level never passes the store depth
  `BRB_ASSERT_IMP(a_fill_max, clk, rst_n, out_tvalid, fill_level <= CNT_W'(DEPTH))
  // input side only stalls while a result waits on the sink
  `BRB_ASSERT_IMP(a_stall_src, clk, rst_n, !in_tready, out_tvalid && !out_tready)
  // out_tvalid is high once an accepted word has passed the read wait stage, for it or an earlier result
  `BRB_ASSERT_DLY2(a_result_due, clk, rst_n, in_tvalid && in_tready, out_tvalid)

endmodule

>>> design/brb_ram.sv
// ----------------------------------------------------------------------------
// brb_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// pointer and fill-count bookkeeping, drives the store ports
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  opcode_t             opcode,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic [OFFSET_W-1:0] offset,
  input  logic [CNT_W-1:0]    count,
  output logic                ram_wr_en,
  output logic [PTR_W-1:0]    ram_wr_addr,
  output logic [DATA_W-1:0]   ram_wr_data,
  output logic                ram_rd_en,
  output logic [PTR_W-1:0]    ram_rd_addr,
  output brb_res_t            res
);

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] clamp;
  logic [CNT_W-1:0] offset_ext;

  assign offset_ext  = {{(CNT_W-OFFSET_W){1'b0}}, offset};
  assign clamp       = (count < cnt_r) ? count : cnt_r;
  assign ram_wr_addr = wr_ptr_r;
  assign ram_wr_data = data_byte;
  assign ram_rd_addr = wrap_add(rd_ptr_r, offset_ext);

  always_comb begin
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    cnt_nxt     = cnt_r;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    res.is_peek = 1'b0;
    res.status  = ST_OK;
    res.dropped = '0;
    if (in_fire) begin
      unique case (opcode)
        OP_APPEND: begin
          if (cnt_r == CNT_W'(DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            ram_wr_en  = 1'b1;
            wr_ptr_nxt = wrap_add(wr_ptr_r, CNT_W'(1));
            cnt_nxt    = cnt_r + CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (offset_ext >= cnt_r) begin
            res.status = ST_RANGE;
          end else begin
            ram_rd_en   = 1'b1;
            res.is_peek = 1'b1;
          end
        end
        OP_CONSUME: begin
          res.dropped = clamp;
          cnt_nxt     = cnt_r - clamp;
          rd_ptr_nxt  = wrap_add(rd_ptr_r, clamp);
          // empty store: both pointers back to the base
          if (cnt_r == clamp) begin
            rd_ptr_nxt = '0;
            wr_ptr_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    res.fill = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/brb_out.sv
// ----------------------------------------------------------------------------
// brb_out
// waits out the store read, then holds the result word for the sink
// ----------------------------------------------------------------------------
module brb_out
  import brb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  brb_res_t          in_res,
  input  logic [DATA_W-1:0] ram_rd_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_peek_byte,
  output status_t           out_status,
  output logic [CNT_W-1:0]  out_fill,
  output logic [CNT_W-1:0]  out_dropped
);

  logic     s1_vld_r, s1_vld_nxt;
  brb_res_t s1_res_r;
  logic     out_vld_r, out_vld_nxt;
  logic     advance;

  // read stage moves on when the output register is free or being drained
  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;

  always_comb begin
    s1_vld_nxt  = s1_vld_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (advance) begin
      out_vld_nxt = 1'b1;
      s1_vld_nxt  = 1'b0;
    end
    if (in_fire) begin
      s1_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_res_r <= in_res;
    end
    if (advance) begin
      out_peek_byte <= s1_res_r.is_peek ? ram_rd_data : '0;
      out_status    <= s1_res_r.status;
      out_fill      <= s1_res_r.fill;
      out_dropped   <= s1_res_r.dropped;
    end
  end

  assign out_valid = out_vld_r;

endmodule

>>> sim/byte_ring_checker.sv
// ----------------------------------------------------------------------------
// byte_ring_checker
// watches both word streams of the byte ring buffer, predicts every result
// word from the accepted input words and compares them field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_checker
  import brb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte, offset, count, zero pad
  input  logic [OPC_W-1:0]       in_tuser,   // opcode
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // peek_byte, fill_level, dropped_count, zero pad
  input  logic [STATUS_W-1:0]    out_tuser,  // status
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef struct {
    logic [DATA_W-1:0] peek_byte;
    status_t           status;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  dropped_count;
  } ring_result_t;

  // shadow of the ring contents and pointers
  logic [DATA_W-1:0] shadow_bytes [DEPTH];
  logic [PTR_W-1:0]  oldest_ptr;
  logic [PTR_W-1:0]  append_ptr;
  logic [CNT_W-1:0]  stored_bytes;

  ring_result_t queued_results [$];

  initial begin
    fail_count = 0;
    checked    = 0;
  end

  assign pending = queued_results.size();

  // applies one operation to the shadow ring and returns the result word it gives
  task automatic apply_ring_op(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] data,
                               input logic [OFFSET_W-1:0] off, input logic [CNT_W-1:0] cnt,
                               output ring_result_t res);
    logic [CNT_W-1:0] removed;
    res.peek_byte     = '0;
    res.status        = ST_OK;
    res.dropped_count = '0;
    case (op)
      OP_APPEND: begin
        if (stored_bytes == CNT_W'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          shadow_bytes[append_ptr] = data;
          append_ptr   = append_ptr + 1'b1;
          stored_bytes = stored_bytes + 1'b1;
        end
      end
      OP_PEEK: begin
        if (CNT_W'(off) >= stored_bytes) begin
          res.status = ST_RANGE;
        end else begin
          res.peek_byte = shadow_bytes[PTR_W'(oldest_ptr + off)];
        end
      end
      OP_CONSUME: begin
        removed = (cnt < stored_bytes) ? cnt : stored_bytes;
        // ring depth is a power of two, so the pointer wraps by truncation
        oldest_ptr   = oldest_ptr + removed[PTR_W-1:0];
        stored_bytes = stored_bytes - removed;
        if (stored_bytes == '0) begin
          oldest_ptr = '0;
          append_ptr = '0;
        end
        res.dropped_count = removed;
      end
      default: begin
      end
    endcase
    res.fill_level = stored_bytes;
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got_res;
    if (!rst_n) begin
      oldest_ptr   = '0;
      append_ptr   = '0;
      stored_bytes = '0;
      queued_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (queued_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with nothing outstanding, actual tdata %h tuser %0d",
                   $time, out_tdata, out_tuser);
        end else begin
          want = queued_results.pop_front();
          checked++;
          check_field("peek_byte", want.peek_byte, out_tdata[DATA_W-1:0]);
          check_field("status", want.status, out_tuser);
          check_field("fill_level", want.fill_level, out_tdata[DATA_W +: CNT_W]);
          check_field("dropped_count", want.dropped_count,
                      out_tdata[DATA_W+CNT_W +: CNT_W]);
          check_field("tdata pad", '0, out_tdata[OUT_TDATA_W-1:OUT_PACK_W]);
        end
      end
      if (in_tvalid && in_tready) begin
        apply_ring_op(in_tuser, in_tdata[DATA_W-1:0], in_tdata[DATA_W +: OFFSET_W],
                      in_tdata[DATA_W+OFFSET_W +: CNT_W], got_res);
        queued_results.push_back(got_res);
      end
    end
  end

endmodule

>>> sim/tb_byte_ring_buffer_peek_consume.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_peek_consume
// drives append, peek, consume and no-op words into the byte ring buffer with random
// gaps and back-pressure; a checker beside the block predicts every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_byte_ring_buffer_peek_consume;
  import brb_pkg::*;

  // opcode value the block must treat as a no-op
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 830;
  localparam int CYCLE_LIMIT  = 1000000;
  // drain time after the last result
  localparam int DRAIN_CYCLES = 8;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // data_byte, offset, count, zero pad
  logic [OPC_W-1:0]       in_tuser;   // opcode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // peek_byte, fill_level, dropped_count, zero pad
  logic [STATUS_W-1:0]    out_tuser;  // status

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping: rough fill level for shaping, word counters for the summary
  int fill_track;
  int sent_words;
  int live_words;
  int range_hits;
  int empty_hits;
  int in_calm;
  int out_calm;
  int cycles;

  byte_ring_buffer_peek_consume i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  byte_ring_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // idle cycles before the next word: mostly 0..13, with calm stretches of no idling
  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // one word on the input stream; valid stays high straight into the next word
  // when no gap is drawn
  task automatic send_word(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] data,
                           input int off, input int cnt);
    int gap;
    gap = draw_idle(in_calm);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = IN_TDATA_W'({CNT_W'(cnt), OFFSET_W'(off), data});
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_words++;
    if (op != OP_UNUSED) live_words++;
    case (op)
      OP_APPEND: begin
        if (fill_track < DEPTH) fill_track++;
      end
      OP_PEEK: begin
        if (off >= fill_track) range_hits++;
      end
      OP_CONSUME: begin
        fill_track -= (cnt < fill_track) ? cnt : fill_track;
        if (fill_track == 0) empty_hits++;
      end
      default: begin
      end
    endcase
  endtask

  // a run of single-byte peeks at consecutive offsets, as a reader looks at a header
  task automatic peek_run(input int start, input int len);
    for (int k = 0; k < len && start + k < DEPTH; k++) begin
      send_word(OP_PEEK, 8'($urandom), start + k, $urandom_range(0, DEPTH));
    end
  endtask

  // result side back-pressure, drawn per word
  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = draw_idle(out_calm);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int start;
    int pick;
    int len;
    int cnt;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_APPEND;
    rst_n      = 1'b0;
    fill_track = 0;
    sent_words = 0;
    live_words = 0;
    range_hits = 0;
    empty_hits = 0;
    in_calm    = 0;
    out_calm   = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, field extremes, clamping and the no-op opcode
    send_word(OP_PEEK, 8'h00, 0, 0);              // peek on an empty store
    send_word(OP_CONSUME, 8'hff, DEPTH - 1, DEPTH); // consume on empty drops nothing
    send_word(OP_UNUSED, 8'hff, DEPTH - 1, DEPTH);
    send_word(OP_APPEND, 8'h00, 0, 0);
    send_word(OP_APPEND, 8'hff, DEPTH - 1, DEPTH);
    send_word(OP_APPEND, 8'h5a, 0, 0);
    send_word(OP_PEEK, 8'h00, 0, 0);
    send_word(OP_PEEK, 8'h00, 2, 0);
    send_word(OP_PEEK, 8'h00, 3, 0);              // just past the stored bytes
    send_word(OP_PEEK, 8'hff, DEPTH - 1, DEPTH);  // largest offset, out of range
    send_word(OP_CONSUME, 8'h00, 0, 0);           // zero-length consume
    send_word(OP_CONSUME, 8'h00, 0, 1);
    send_word(OP_PEEK, 8'h00, 0, 0);
    send_word(OP_CONSUME, 8'h00, 0, DEPTH);       // clamps to the fill and empties
    send_word(OP_APPEND, 8'ha5, 0, 0);            // lands at address zero again
    send_word(OP_PEEK, 8'h00, 0, 0);
    send_word(OP_UNUSED, 8'($urandom), $urandom_range(0, DEPTH - 1),
              $urandom_range(0, DEPTH));

    // random: mostly well-formed append bursts, peek runs and consumes, some noise
    start = live_words;
    while (live_words - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = $urandom_range(1, 48);
        repeat (len) begin
          send_word(OP_APPEND, 8'($urandom), $urandom_range(0, DEPTH - 1),
                    $urandom_range(0, DEPTH));
        end
      end else if (pick < 65) begin
        len = $urandom_range(1, 16);
        if (fill_track < DEPTH && $urandom_range(0, 7) == 0) begin
          peek_run($urandom_range(fill_track, DEPTH - 1), len);
        end else if (fill_track > 0) begin
          peek_run($urandom_range(0, fill_track - 1), len);
        end else begin
          peek_run(0, 1);
        end
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: cnt = $urandom_range(0, (fill_track < 32) ? fill_track : 32);
          1: cnt = $urandom_range(0, fill_track);
          2: cnt = $urandom_range(fill_track, DEPTH);  // clamped by the block
          default: cnt = $urandom_range(0, 1) ? DEPTH : 0;
        endcase
        send_word(OP_CONSUME, 8'($urandom), $urandom_range(0, DEPTH - 1), cnt);
      end else begin
        send_word(2'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, DEPTH - 1),
                  $urandom_range(0, DEPTH));
      end
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input words sent (%0d random), %0d results checked", sent_words,
             live_words - start, checked);
    $display("%0d peeks out of range, %0d consumes that left the store empty",
             range_hits, empty_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
